/* design/eds_pkg.sv */
// Shared constants and types of the earliest-due poll scheduler.
// Used by every module in this folder; depends on nothing.
package eds_pkg;

    localparam int POINT_COUNT = 16;
    localparam int MASK_POINTS = (POINT_COUNT < 16) ? POINT_COUNT : 16;
    localparam int PT_W        = (POINT_COUNT > 16) ? $clog2(POINT_COUNT) : 4;
    localparam int TIME_W      = 32;
    localparam int REG_W       = 16;
    localparam int PACK_W      = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [REG_W-1:0] MIN_GAP_RESET = 16'd20;
    localparam logic [REG_W-1:0] STAGGER_RESET = 16'd50;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAGGER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTV_A      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTV_B      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTV_C      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTV_D      = 3'd6;

    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    typedef struct packed {
        logic            clear;
        logic            check;
        logic [PT_W-1:0] idx;
    } eds_scan_t;

endpackage

/* design/earliest_due_poll_scheduler.sv */
// Earliest-due poll scheduler: a ring of due-time cells scanned one point per cycle.
// A start or a poll word gives its result after a full pass of the ring, through the finish
// state; a poll inside the minimum gap goes to the finish state straight from idle. One word
// at a time, so a new word is taken only once the last has left the finish state.
// Synchronous active-low reset clears all due times and the last scan time and sets the
// configuration registers to their reset values. Depends on eds_pkg, eds_cell and eds_picker.
module earliest_due_poll_scheduler
    import eds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [TIME_W-1:0]     s_now_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_dispatched,
    output logic [3:0]            m_point_index,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_STAGGER = 2'd1;
    localparam logic [1:0] ST_SCAN    = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [PT_W-1:0]   cnt_reg, cnt_next;
    logic              op_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] acc_reg;
    logic [TIME_W-1:0] last_scan_reg;

    logic [REG_W-1:0]  enable_mask_reg;
    logic [REG_W-1:0]  min_gap_reg;
    logic [REG_W-1:0]  stagger_reg;
    logic [PACK_W-1:0] intv_pack_reg [4];

    logic              m_valid_reg;
    logic              m_dispatched_reg;
    logic [3:0]        m_point_index_reg;

    logic [TIME_W-1:0] due [POINT_COUNT];
    logic [TIME_W-1:0] tail_in;
    logic [TIME_W-1:0] load_val;
    logic [REG_W-1:0]  interval;
    logic [TIME_W-1:0] gap;
    logic              accept;
    logic              shift_en;
    logic              last_step;
    logic              out_free;
    logic              finish;
    logic              found;
    logic [PT_W-1:0]   pick;
    logic              enabled;
    logic [3:0]        mask_idx;
    eds_scan_t         scan;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign shift_en  = (state_reg == ST_STAGGER) || (state_reg == ST_SCAN);
    assign last_step = (cnt_reg == PT_W'(POINT_COUNT - 1));
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == ST_FINISH) && out_free;
    assign gap       = s_now_ms - last_scan_reg;
    assign tail_in   = (state_reg == ST_STAGGER) ? acc_reg : due[0];
    assign mask_idx  = cnt_reg[3:0];
    assign enabled   = ({1'b0, cnt_reg} < (PT_W+1)'(MASK_POINTS))
                       && enable_mask_reg[mask_idx];
    assign interval  = intv_pack_reg[pick[3:2]][{pick[1:0], 4'b0000} +: REG_W];
    assign load_val  = now_reg + {{(TIME_W-REG_W){1'b0}}, interval};

    assign scan.clear = accept;
    assign scan.check = (state_reg == ST_SCAN);
    assign scan.idx   = cnt_reg;

    genvar k;
    generate
        for (k = 0; k < POINT_COUNT; k++) begin : g_cell
            logic [TIME_W-1:0] shift_in;
            if (k == POINT_COUNT - 1) begin : g_tail
                assign shift_in = tail_in;
            end else begin : g_body
                assign shift_in = due[k+1];
            end
            eds_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .shift_in (shift_in),
                .load_en  (finish && found && (pick == PT_W'(k))),
                .load_val (load_val),
                .due      (due[k])
            );
        end
    endgenerate

    eds_picker u_picker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .scan     (scan),
        .enabled  (enabled),
        .head_due (due[0]),
        .now      (now_reg),
        .found    (found),
        .pick     (pick)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    if (s_operation == OP_START) begin
                        state_next = ST_STAGGER;
                    end else if (gap < {{(TIME_W-REG_W){1'b0}}, min_gap_reg}) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_STAGGER, ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_operation;
            now_reg <= s_now_ms;
            acc_reg <= s_now_ms;
        end else if (state_reg == ST_STAGGER) begin
            acc_reg <= acc_reg + {{(TIME_W-REG_W){1'b0}}, stagger_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_scan_reg <= '0;
        end else if (finish && ((op_reg == OP_START) || found)) begin
            last_scan_reg <= now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_mask_reg  <= '0;
            min_gap_reg      <= MIN_GAP_RESET;
            stagger_reg      <= STAGGER_RESET;
            intv_pack_reg[0] <= '0;
            intv_pack_reg[1] <= '0;
            intv_pack_reg[2] <= '0;
            intv_pack_reg[3] <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENABLE_MASK: enable_mask_reg  <= cfg_data[REG_W-1:0];
                REG_MIN_GAP:     min_gap_reg      <= cfg_data[REG_W-1:0];
                REG_STAGGER:     stagger_reg      <= cfg_data[REG_W-1:0];
                REG_INTV_A:      intv_pack_reg[0] <= cfg_data;
                REG_INTV_B:      intv_pack_reg[1] <= cfg_data;
                REG_INTV_C:      intv_pack_reg[2] <= cfg_data;
                REG_INTV_D:      intv_pack_reg[3] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_dispatched_reg  <= found;
            m_point_index_reg <= found ? pick[3:0] : 4'd0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_dispatched  = m_dispatched_reg;
    assign m_point_index = m_point_index_reg;

endmodule

/* design/eds_cell.sv */
// One cell of the due-time ring: holds the due time of one point.
// Shifts toward the head each cycle of a pass, or loads a new value. Uses eds_pkg.
module eds_cell
    import eds_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic [TIME_W-1:0] shift_in,
    input  logic              load_en,
    input  logic [TIME_W-1:0] load_val,
    output logic [TIME_W-1:0] due
);

    logic [TIME_W-1:0] due_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            due_reg <= '0;
        end else if (shift_en) begin
            due_reg <= shift_in;
        end else if (load_en) begin
            due_reg <= load_val;
        end
    end

    assign due = due_reg;

endmodule

/* design/eds_picker.sv */
// Running earliest-due selection over the word at the head of the ring.
// Keeps the best due time and its index across one scan pass. Uses eds_pkg.
module eds_picker
    import eds_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  eds_scan_t         scan,
    input  logic              enabled,
    input  logic [TIME_W-1:0] head_due,
    input  logic [TIME_W-1:0] now,
    output logic              found,
    output logic [PT_W-1:0]   pick
);

    logic              found_reg;
    logic [PT_W-1:0]   pick_reg;
    logic [TIME_W-1:0] best_reg;
    logic [TIME_W-1:0] late_diff;
    logic [TIME_W-1:0] best_diff;
    logic              take;

    assign late_diff = now - head_due;
    assign best_diff = head_due - best_reg;
    assign take = scan.check && enabled && !late_diff[TIME_W-1]
                  && (!found_reg || best_diff[TIME_W-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (scan.clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pick_reg <= scan.idx;
            best_reg <= head_due;
        end else if (scan.clear) begin
            pick_reg <= '0;
        end
    end

    assign found = found_reg;
    assign pick  = pick_reg;

endmodule

/* design/eds_checker.sv */
// Port-level checks of the earliest-due poll scheduler, bound to the top level.
// Depends on eds_pkg and earliest_due_poll_scheduler.
module eds_checker
    import eds_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_dispatched,
    input logic [3:0]            m_point_index
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dispatched) && $stable(m_point_index))
        else $error("Result word changed while stalled.");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dispatched |-> m_point_index == 4'd0)
        else $error("Point index is not zero without a dispatch.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("A new word was taken while one is in progress.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

endmodule

bind earliest_due_poll_scheduler eds_checker u_eds_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_dispatched  (m_dispatched),
    .m_point_index (m_point_index)
);

/* test/earliest_due_poll_scheduler_tb.sv */
// Testbench for earliest_due_poll_scheduler: directed and random start and poll words under
// random idling and long back-pressure, each result checked against a local due-time model.
// Depends on eds_pkg and the design files; reads nothing else.
module earliest_due_poll_scheduler_tb;
    import eds_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = POINT_COUNT + 12;

    typedef struct packed {
        logic       dispatched;
        logic [3:0] point_index;
    } pick_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_operation;
    logic [TIME_W-1:0]     s_now_ms;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_dispatched;
    logic [3:0]            m_point_index;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [REG_W-1:0]  enable_mask_q;
    logic [REG_W-1:0]  min_gap_q;
    logic [REG_W-1:0]  stagger_q;
    logic [PACK_W-1:0] interval_pack_q [4];
    logic [TIME_W-1:0] due_time_q [POINT_COUNT];
    logic [TIME_W-1:0] last_scan_q;

    pick_t             expected_picks [$];
    int                mismatch_count = 0;
    bit                send_idle_en;
    bit                recv_idle_en;
    int                recv_hold_cycles = 0;
    logic [TIME_W-1:0] clock_ms;

    earliest_due_poll_scheduler i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dispatched  (m_dispatched),
        .m_point_index (m_point_index),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic pick_t schedule_word(logic op, logic [TIME_W-1:0] now);
        pick_t             res;
        logic              found;
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] diff;
        int                pick;
        res   = '0;
        found = 1'b0;
        best  = '0;
        pick  = 0;
        if (op == OP_START) begin
            for (int i = 0; i < POINT_COUNT; i++) begin
                due_time_q[i] = now + TIME_W'(i) * TIME_W'(stagger_q);
            end
            last_scan_q = now;
            return res;
        end
        diff = now - last_scan_q;
        if (diff < TIME_W'(min_gap_q)) begin
            return res;
        end
        for (int i = 0; i < POINT_COUNT; i++) begin
            if (i < 16) begin
                if (enable_mask_q[i]) begin
                    diff = now - due_time_q[i];
                    if (!diff[TIME_W-1]) begin
                        diff = due_time_q[i] - best;
                        if (!found || diff[TIME_W-1]) begin
                            found = 1'b1;
                            pick  = i;
                            best  = due_time_q[i];
                        end
                    end
                end
            end
        end
        if (!found) begin
            return res;
        end
        due_time_q[pick] = now + TIME_W'(interval_pack_q[pick >> 2][(pick & 3) * 16 +: 16]);
        last_scan_q = now;
        res.dispatched  = 1'b1;
        res.point_index = 4'(pick);
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        case (idx)
            REG_ENABLE_MASK: enable_mask_q = data[REG_W-1:0];
            REG_MIN_GAP:     min_gap_q = data[REG_W-1:0];
            REG_STAGGER:     stagger_q = data[REG_W-1:0];
            REG_INTV_A:      interval_pack_q[0] = data;
            REG_INTV_B:      interval_pack_q[1] = data;
            REG_INTV_C:      interval_pack_q[2] = data;
            REG_INTV_D:      interval_pack_q[3] = data;
            default: ;
        endcase
    endtask

    task automatic send_word(input logic op, input logic [TIME_W-1:0] now);
        int gap;
        gap = send_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_now_ms    <= now;
        do @(posedge aclk); while (!s_ready);
        expected_picks.push_back(schedule_word(op, now));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_picks.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic load_random_config();
        logic [REG_W-1:0]      mask;
        logic [REG_W-1:0]      gap;
        logic [REG_W-1:0]      stagger;
        logic [CFG_DATA_W-1:0] pack;
        case ($urandom_range(0, 3))
            0: mask = 16'hFFFF;
            1: mask = 16'h1 << $urandom_range(0, 15);
            default: mask = 16'($urandom);
        endcase
        gap = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        stagger = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
        write_reg(REG_ENABLE_MASK, {32'($urandom), 16'($urandom), mask});
        write_reg(REG_MIN_GAP, {32'($urandom), 16'($urandom), gap});
        write_reg(REG_STAGGER, {32'($urandom), 16'($urandom), stagger});
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
                pack[j * 16 +: 16] = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 200));
            end
            write_reg(CFG_IDX_W'(REG_INTV_A + k), pack);
        end
    endtask

    task automatic run_traffic_phase(input int count);
        int kind;
        clock_ms = $urandom;
        send_word(OP_START, clock_ms);
        for (int n = 1; n < count; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 3) begin
                clock_ms = clock_ms + $urandom_range(0, 200);
                send_word(OP_START, clock_ms);
            end else begin
                if (kind < 5) begin
                    clock_ms = $urandom;
                end else if (kind < 10) begin
                    clock_ms = clock_ms + $urandom_range(0, 70000);
                end else if (kind < 12) begin
                    clock_ms = clock_ms - $urandom_range(0, 100);
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, 2 * min_gap_q + 40);
                end
                send_word(OP_POLL, clock_ms);
            end
        end
    endtask

    // Reset values: nothing enabled, so polls never dispatch.
    task automatic test_reset_state();
        send_word(OP_POLL, 32'h0000_0000);
        send_word(OP_POLL, 32'hFFFF_FFFF);
        send_word(OP_START, 32'h0000_0000);
        send_word(OP_POLL, 32'h0000_0064);
        wait_idle();
        write_reg(REG_UNUSED, '1);
    endtask

    // All points due together with zero gap, stagger and interval, across the wrap point.
    task automatic test_tie_and_wrap();
        write_reg(REG_ENABLE_MASK, 64'h0000_0000_0000_FFFF);
        write_reg(REG_MIN_GAP, '0);
        write_reg(REG_STAGGER, '0);
        write_reg(REG_INTV_A, '0);
        write_reg(REG_INTV_B, '0);
        write_reg(REG_INTV_C, '0);
        write_reg(REG_INTV_D, '0);
        send_word(OP_START, 32'hFFFF_FFF0);
        send_word(OP_POLL, 32'hFFFF_FFF0);
        send_word(OP_POLL, 32'hFFFF_FFF0);
        send_word(OP_POLL, 32'hFFFF_FFE0);
        send_word(OP_POLL, 32'h0000_0010);
        wait_idle();
    endtask

    task automatic test_extreme_settings();
        write_reg(REG_ENABLE_MASK, 64'hFFFF_FFFF_FFFF_8001);
        write_reg(REG_MIN_GAP, '1);
        write_reg(REG_STAGGER, '1);
        write_reg(REG_INTV_A, '1);
        write_reg(REG_INTV_B, '1);
        write_reg(REG_INTV_C, '1);
        write_reg(REG_INTV_D, '1);
        send_word(OP_START, 32'h7FFF_0000);
        send_word(OP_POLL, 32'h7FFF_FFFE);
        send_word(OP_POLL, 32'h7FFF_FFFF);
        send_word(OP_POLL, 32'h8000_FFFE);
        send_word(OP_POLL, 32'h8010_0000);
        send_word(OP_POLL, 32'h8020_0000);
        send_word(OP_POLL, 32'h8030_0000);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            load_random_config();
            send_idle_en = (phase % 4) != 3;
            recv_idle_en = (phase % 3) != 2;
            run_traffic_phase(170);
        end
        wait_idle();
    endtask

    // The sink holds off for a long stretch so the result output stalls and the block stops taking words.
    task automatic test_backpressure();
        load_random_config();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b1;
        recv_hold_cycles = 300;
        run_traffic_phase(40);
        wait_idle();
    endtask

    task automatic test_sender_pause();
        send_idle_en = 1'b1;
        run_traffic_phase(30);
        wait_idle();
        run_traffic_phase(30);
        wait_idle();
    endtask

    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = recv_idle_en ? $urandom_range(0, 4) : 0;
            if (recv_hold_cycles > 0) begin
                gap = recv_hold_cycles;
                recv_hold_cycles = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        pick_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_picks.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with none expected: dispatched %0d point_index %0d",
                         $time, m_dispatched, m_point_index);
            end else begin
                want = expected_picks.pop_front();
                if (m_dispatched !== want.dispatched) begin
                    mismatch_count++;
                    $display("%0t: dispatched expected %0d actual %0d",
                             $time, want.dispatched, m_dispatched);
                end
                if (m_point_index !== want.point_index) begin
                    mismatch_count++;
                    $display("%0t: point_index expected %0d actual %0d",
                             $time, want.point_index, m_point_index);
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_START;
        s_now_ms    = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_ENABLE_MASK;
        cfg_data    = '0;
        enable_mask_q = '0;
        min_gap_q     = MIN_GAP_RESET;
        stagger_q     = STAGGER_RESET;
        for (int k = 0; k < 4; k++) begin
            interval_pack_q[k] = '0;
        end
        for (int i = 0; i < POINT_COUNT; i++) begin
            due_time_q[i] = '0;
        end
        last_scan_q  = '0;
        clock_ms     = '0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_tie_and_wrap();
        test_extreme_settings();
        test_random_traffic();
        test_backpressure();
        test_sender_pause();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
